// ----- hdl/iqnco_pkg.sv -----
// Shared types, widths and register codes for the IQ byte NCO mixer.
// No dependencies; every other file of the block imports this package.
package iqnco_pkg;

   // Field widths of the channels
   localparam int SAMPLE_W = 8;
   localparam int COEF_W   = 16;
   localparam int RESULT_W = 24;
   localparam int FREQ_W   = 21;

   // Configuration port: 32-bit data, one register at byte address 0
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_INDEX_LSB = 2;
   localparam int CSR_INDEX_W   = CSR_ADDR_W - CSR_INDEX_LSB;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_FREQ_OFFSET = csr_index_type'(0);

   // Datapath pipeline: phase multiply, quotient multiply, index, table, result
   localparam int PIPE_STAGES = 5;

   // Oscillator table scaling
   localparam real TWO_PI         = 6.283185307179586;
   localparam real COEF_AMPLITUDE = 32767.0;

   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [CSR_DATA_W-1:0] pwdata;
   } csr_req_type;

   // Load strobes, one per pipeline stage
   typedef struct packed {
      logic phase_mul;
      logic quot_mul;
      logic index;
      logic table_rd;
      logic result;
   } pipe_en_type;

   // Recentred sample pair, signed Q1.7
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] i;
      logic signed [SAMPLE_W-1:0] q;
   } sample_pair_type;

   // Round 32767*v to the nearest integer, halves away from zero
   function automatic logic signed [COEF_W-1:0] coef_q15(real v);
      real scaled;
      scaled = COEF_AMPLITUDE * v;
      if (scaled >= 0.0) begin
         return COEF_W'($rtoi(scaled + 0.5));
      end else begin
         return COEF_W'($rtoi(scaled - 0.5));
      end
   endfunction

endpackage

// ----- hdl/iqnco_req_if.sv -----
// Input channel of the mixer: one raw offset-binary IQ byte pair per transfer.
// Depends on iqnco_pkg for the sample width.
interface iqnco_req_if;
   import iqnco_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] i_sample;
   logic [SAMPLE_W-1:0] q_sample;

   modport source (output valid, output i_sample, output q_sample, input ready);
   modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

// ----- hdl/iqnco_rsp_if.sv -----
// Result channel of the mixer: one mixed Q2.22 IQ pair per transfer.
// Depends on iqnco_pkg for the result width.
interface iqnco_rsp_if;
   import iqnco_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] i_out;
   logic signed [RESULT_W-1:0] q_out;

   modport source (output valid, output i_out, output q_out, input ready);
   modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

// ----- hdl/iqnco_nco.sv -----
// Frequency offset register, its reduction modulo the phase modulus, and the
// phase accumulator. Depends on iqnco_pkg.
module iqnco_nco #(
   parameter int PHASE_MODULUS = 2048000,
   localparam int PhaseW = $clog2(PHASE_MODULUS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  iqnco_pkg::csr_req_type          csr_req,
   output logic [iqnco_pkg::CSR_DATA_W-1:0] csr_rdata,
   input  logic                            advance,
   output logic                            busy,
   output logic [PhaseW-1:0]               phase
);
   import iqnco_pkg::*;

   localparam longint unsigned Recip = (64'd1 << FREQ_W) / PHASE_MODULUS;
   localparam int RecipW = $clog2(Recip + 1);
   localparam int ModW   = $clog2(PHASE_MODULUS + 1);
   localparam int ProdW  = FREQ_W + RecipW;
   localparam int QmW    = RecipW + ModW;

   logic                  csr_wr;
   logic                  wr_offset;
   csr_index_type         csr_index;
   logic [FREQ_W-1:0]     offset_ff;
   logic [2:0]            pend_ff;
   logic [FREQ_W-1:0]     mag;
   logic [ProdW-1:0]      red_prod_ff;
   logic [FREQ_W-1:0]     mag_ff;
   logic                  neg_ff;
   logic                  neg2_ff;
   logic [RecipW-1:0]     quot;
   logic [QmW-1:0]        quot_mod;
   logic [FREQ_W-1:0]     rem_ff;
   logic [FREQ_W:0]       rem_wide;
   logic [FREQ_W:0]       fold_wide;
   logic [PhaseW-1:0]     fold;
   logic [PhaseW:0]       negated;
   logic [PhaseW-1:0]     step_in;
   logic [PhaseW-1:0]     step_ff;
   logic [PhaseW:0]       diff;
   logic [PhaseW:0]       wrapped;
   logic [PhaseW-1:0]     phase_in;
   logic [PhaseW-1:0]     phase_ff;

   // Decode the register transfer
   assign csr_wr    = csr_req.psel & csr_req.penable & csr_req.pwrite;
   assign csr_index = csr_req.paddr[CSR_ADDR_W-1:CSR_INDEX_LSB];
   assign wr_offset = csr_wr && (csr_index == REG_FREQ_OFFSET);

   always_comb begin
      unique case (csr_index)
         REG_FREQ_OFFSET: csr_rdata = {{(CSR_DATA_W-FREQ_W){offset_ff[FREQ_W-1]}}, offset_ff};
         default:         csr_rdata = '0;
      endcase
   end

   // Hold off new items while the reduced step is being recomputed
   assign busy = csr_wr | (|pend_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         pend_ff   <= '0;
      end else begin
         if (wr_offset) begin
            offset_ff <= csr_req.pwdata[FREQ_W-1:0];
         end
         pend_ff <= {pend_ff[1:0], csr_wr};
      end
   end

   // Step one: magnitude times reciprocal of the modulus
   assign mag = offset_ff[FREQ_W-1] ? FREQ_W'(~offset_ff + FREQ_W'(1)) : offset_ff;

   always_ff @(posedge clock) begin
      if (pend_ff[0]) begin
         red_prod_ff <= ProdW'(mag) * ProdW'(Recip);
         mag_ff      <= mag;
         neg_ff      <= offset_ff[FREQ_W-1];
      end
   end

   // Step two: remainder estimate, off by at most one modulus
   assign quot     = red_prod_ff[FREQ_W +: RecipW];
   assign quot_mod = QmW'(quot) * QmW'(PHASE_MODULUS);

   always_ff @(posedge clock) begin
      if (pend_ff[1]) begin
         rem_ff  <= mag_ff - quot_mod[FREQ_W-1:0];
         neg2_ff <= neg_ff;
      end
   end

   // Step three: correct the remainder and fold negative offsets
   assign rem_wide  = {1'b0, rem_ff};
   assign fold_wide = (rem_wide >= (FREQ_W+1)'(PHASE_MODULUS)) ?
                      rem_wide - (FREQ_W+1)'(PHASE_MODULUS) : rem_wide;
   assign fold      = fold_wide[PhaseW-1:0];
   assign negated   = (PhaseW+1)'(PHASE_MODULUS) - {1'b0, fold};
   assign step_in   = (neg2_ff && (fold != '0)) ? negated[PhaseW-1:0] : fold;

   // Advance the phase by minus the step on every accepted item
   assign diff     = {1'b0, phase_ff} - {1'b0, step_ff};
   assign wrapped  = diff + (PhaseW+1)'(PHASE_MODULUS);
   assign phase_in = diff[PhaseW] ? wrapped[PhaseW-1:0] : diff[PhaseW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         phase_ff <= '0;
      end else begin
         if (pend_ff[2]) begin
            step_ff <= step_in;
         end
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   assign phase = phase_ff;
endmodule

// ----- hdl/iqnco_index.sv -----
// Phase to table index, floor(phase*depth/modulus), by a reciprocal multiply
// and one correction over three stages. Depends on iqnco_pkg.
module iqnco_index #(
   parameter int PHASE_MODULUS = 2048000,
   parameter int TABLE_DEPTH = 1024,
   localparam int PhaseW = $clog2(PHASE_MODULUS),
   localparam int IdxW = $clog2(TABLE_DEPTH)
) (
   input  logic                   clock,
   input  iqnco_pkg::pipe_en_type en,
   input  logic [PhaseW-1:0]      phase,
   output logic [IdxW-1:0]        idx
);
   import iqnco_pkg::*;

   localparam longint unsigned Recip =
      (64'(TABLE_DEPTH) << PhaseW) / PHASE_MODULUS;
   localparam int RecipW = $clog2(Recip + 1);
   localparam int DepthW = $clog2(TABLE_DEPTH + 1);
   localparam int ProdW  = PhaseW + RecipW;
   localparam int XW     = PhaseW + DepthW;

   logic [ProdW-1:0] prod_ff;
   logic [XW-1:0]    x_ff;
   logic [XW-1:0]    x2_ff;
   logic [IdxW-1:0]  quot;
   logic [IdxW-1:0]  quot_ff;
   logic [XW-1:0]    quot_mod_ff;
   logic [XW-1:0]    rem;
   logic             bump;
   logic [IdxW:0]    next_idx;
   logic [IdxW-1:0]  idx_ff;

   // Stage one: estimate and exact numerator
   always_ff @(posedge clock) begin
      if (en.phase_mul) begin
         prod_ff <= ProdW'(phase) * ProdW'(Recip);
         x_ff    <= XW'(phase) * XW'(TABLE_DEPTH);
      end
   end

   // Stage two: quotient estimate back times the modulus
   assign quot = prod_ff[PhaseW +: IdxW];

   always_ff @(posedge clock) begin
      if (en.quot_mul) begin
         quot_ff     <= quot;
         quot_mod_ff <= XW'(quot) * XW'(PHASE_MODULUS);
         x2_ff       <= x_ff;
      end
   end

   // Stage three: bump the estimate when the remainder reaches the modulus
   assign rem      = x2_ff - quot_mod_ff;
   assign bump     = rem >= XW'(PHASE_MODULUS);
   assign next_idx = {1'b0, quot_ff} + (IdxW+1)'(bump);

   always_ff @(posedge clock) begin
      if (en.index) begin
         idx_ff <= (next_idx >= (IdxW+1)'(TABLE_DEPTH)) ?
                   IdxW'(TABLE_DEPTH - 1) : next_idx[IdxW-1:0];
      end
   end

   assign idx = idx_ff;
endmodule

// ----- hdl/iqnco_rom.sv -----
// Cosine and sine ROM, Q1.15, built at elaboration, registered read.
// Depends on iqnco_pkg for the coefficient width and rounding function.
module iqnco_rom #(
   parameter int TABLE_DEPTH = 1024,
   localparam int IdxW = $clog2(TABLE_DEPTH)
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [IdxW-1:0]                     idx,
   output logic signed [iqnco_pkg::COEF_W-1:0] cos_val,
   output logic signed [iqnco_pkg::COEF_W-1:0] sin_val
);
   import iqnco_pkg::*;

   typedef logic [2*COEF_W-1:0] rom_type [TABLE_DEPTH];

   localparam real StepAngle = TWO_PI / TABLE_DEPTH;

   function automatic rom_type build_rom();
      rom_type rom;
      real     angle;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         angle  = real'(k) * StepAngle;
         rom[k] = {coef_q15($cos(angle)), coef_q15($sin(angle))};
      end
      return rom;
   endfunction

   localparam rom_type Rom = build_rom();

   logic [2*COEF_W-1:0] word_ff;

   // Read one cosine/sine pair per load
   always_ff @(posedge clock) begin
      if (rd_en) begin
         word_ff <= Rom[idx];
      end
   end

   assign cos_val = word_ff[2*COEF_W-1:COEF_W];
   assign sin_val = word_ff[COEF_W-1:0];
endmodule

// ----- hdl/iqnco_mult.sv -----
// Complex multiply of a Q1.7 sample pair by a Q1.15 oscillator value into the
// Q2.22 result register. Depends on iqnco_pkg.
module iqnco_mult (
   input  logic                                  clock,
   input  logic                                  load,
   input  iqnco_pkg::sample_pair_type            smp,
   input  logic signed [iqnco_pkg::COEF_W-1:0]   cos_val,
   input  logic signed [iqnco_pkg::COEF_W-1:0]   sin_val,
   output logic signed [iqnco_pkg::RESULT_W-1:0] i_out,
   output logic signed [iqnco_pkg::RESULT_W-1:0] q_out
);
   import iqnco_pkg::*;

   localparam int SumW = SAMPLE_W + COEF_W + 1;

   logic signed [SumW-1:0]     i_sum;
   logic signed [SumW-1:0]     q_sum;
   logic signed [RESULT_W-1:0] i_out_ff;
   logic signed [RESULT_W-1:0] q_out_ff;

   // i*cos - q*sin and i*sin + q*cos
   assign i_sum = smp.i * cos_val - smp.q * sin_val;
   assign q_sum = smp.i * sin_val + smp.q * cos_val;

   always_ff @(posedge clock) begin
      if (load) begin
         i_out_ff <= i_sum[RESULT_W-1:0];
         q_out_ff <= q_sum[RESULT_W-1:0];
      end
   end

   assign i_out = i_out_ff;
   assign q_out = q_out_ff;
endmodule

// ----- hdl/iq_byte_nco_mixer.sv -----
// IQ byte NCO mixer: shifts a stream of raw offset-binary IQ byte pairs in
// frequency by a numerically controlled oscillator.
// Depends on iqnco_pkg, iqnco_req_if, iqnco_rsp_if and the iqnco_* modules.
//
// Usage:
//   req_bus carries one raw byte pair per transfer (128 means zero), rsp_bus
//   one mixed Q2.22 pair per transfer. The csr_ port is APB-style with one
//   register, frequency_offset, at byte address 0; pready is tied high.
//   One item is accepted every cycle while no register write is pending and
//   rsp_bus does not stall: phase multiply, quotient multiply, index
//   correction, table read and complex multiply each take a stage.
//   After a register write, req_bus.ready stays low during the write and
//   while the new step is reduced modulo PHASE_MODULUS.
//   Reset clears the phase and the offset to zero and empties the pipeline;
//   req_bus.ready is low while reset is high.
//   When rsp_bus stalls, the pipeline closes its bubbles and keeps taking
//   items until all 5 stages hold one; then req_bus.ready drops.
module iq_byte_nco_mixer #(
   parameter int PHASE_MODULUS = 2048000,
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   iqnco_req_if.sink                           req_bus,
   iqnco_rsp_if.source                         rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [iqnco_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [iqnco_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [iqnco_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import iqnco_pkg::*;

   localparam int PhaseW = $clog2(PHASE_MODULUS);
   localparam int IdxW   = $clog2(TABLE_DEPTH);

   csr_req_type                csr_req;
   logic                       busy;
   logic                       accept;
   logic [PhaseW-1:0]          phase;
   logic [PIPE_STAGES-1:0]     load;
   logic [PIPE_STAGES-1:0]     valid_in;
   logic [PIPE_STAGES-1:0]     valid_ff;
   pipe_en_type                en;
   sample_pair_type            smp_ff [PIPE_STAGES-1];
   logic [IdxW-1:0]            idx;
   logic signed [COEF_W-1:0]   cos_val;
   logic signed [COEF_W-1:0]   sin_val;

   assign csr_req    = '{psel: csr_psel, penable: csr_penable, pwrite: csr_pwrite,
                         paddr: csr_paddr, pwdata: csr_pwdata};
   assign csr_pready = 1'b1;

   // Load strobes: a stage takes new data when empty or when its successor moves
   always_comb begin
      load[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_bus.ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_bus.ready = load[0] && !busy && !reset;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in[0] = load[0] ? accept : valid_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en = '{phase_mul: load[0], quot_mul: load[1], index: load[2],
                 table_rd: load[3], result: load[4]};

   // Recentre the bytes on transfer and carry them alongside the index stages
   always_ff @(posedge clock) begin
      if (load[0]) begin
         smp_ff[0] <= '{i: {~req_bus.i_sample[SAMPLE_W-1], req_bus.i_sample[SAMPLE_W-2:0]},
                        q: {~req_bus.q_sample[SAMPLE_W-1], req_bus.q_sample[SAMPLE_W-2:0]}};
      end
      for (int k = 1; k < PIPE_STAGES - 1; k++) begin
         if (load[k]) begin
            smp_ff[k] <= smp_ff[k-1];
         end
      end
   end

   iqnco_nco #(
      .PHASE_MODULUS(PHASE_MODULUS)
   ) u_nco (
      .clock    (clock),
      .reset    (reset),
      .csr_req  (csr_req),
      .csr_rdata(csr_prdata),
      .advance  (accept),
      .busy     (busy),
      .phase    (phase)
   );

   iqnco_index #(
      .PHASE_MODULUS(PHASE_MODULUS),
      .TABLE_DEPTH  (TABLE_DEPTH)
   ) u_index (
      .clock(clock),
      .en   (en),
      .phase(phase),
      .idx  (idx)
   );

   iqnco_rom #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_en  (en.table_rd),
      .idx    (idx),
      .cos_val(cos_val),
      .sin_val(sin_val)
   );

   iqnco_mult u_mult (
      .clock  (clock),
      .load   (en.result),
      .smp    (smp_ff[PIPE_STAGES-2]),
      .cos_val(cos_val),
      .sin_val(sin_val),
      .i_out  (rsp_bus.i_out),
      .q_out  (rsp_bus.q_out)
   );

   assign rsp_bus.valid = valid_ff[PIPE_STAGES-1];

   // A register write blocks the input for the next cycle
   a_csr_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=> !req_bus.ready)
      else $error("input accepted right after a register write");

   // The phase moves only on an accepted item
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase))
      else $error("phase changed without an input transfer");

   // A full pipeline behind a stalled output takes no item
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted into a full stalled pipeline");

   // An accepted item occupies the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff[0])
      else $error("accepted item lost from the first stage");
endmodule

// ----- tb/iqnco_checker.sv -----
// Scoreboard for the IQ byte NCO mixer: watches both channels and the csr_ port,
// predicts each mixed pair from its own oscillator tables and compares it.
// Depends on iqnco_pkg, iqnco_req_if and iqnco_rsp_if.
`timescale 1ns / 100ps

module iqnco_checker (
   input  logic                               clock,
   input  logic                               reset,
   iqnco_req_if                               req_bus,
   iqnco_rsp_if                               rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [iqnco_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iqnco_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [iqnco_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                               csr_pready,
   output int                                 mismatches,
   output int                                 pending
);
   import iqnco_pkg::*;

   localparam longint      NCO_MODULUS      = 2048000;
   localparam int          LUT_DEPTH        = 1024;
   localparam logic [63:0] UNIT_Q60         = 64'd1 << 60;
   localparam logic [63:0] QUARTER_TURN_Q60 = 64'h1921FB54442D1846;
   localparam int          SERIES_TERMS     = 16;
   localparam int          REPORT_LIMIT     = 10;

   typedef struct packed {
      logic signed [RESULT_W-1:0] i_out;
      logic signed [RESULT_W-1:0] q_out;
   } mixed_pair_type;

   logic signed [COEF_W-1:0] cos_q15 [LUT_DEPTH];
   logic signed [COEF_W-1:0] sin_q15 [LUT_DEPTH];
   mixed_pair_type           mixed_due [$];
   longint                   nco_phase;
   longint                   step_offset;
   int                       errs;

   // (a*b) >> 60 in unsigned Q60
   function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // Scale a signed Q60 value by 32767, rounding halves away from zero
   function automatic logic signed [COEF_W-1:0] q15_round(longint v);
      logic [63:0]              m;
      logic [63:0]              r;
      logic signed [COEF_W-1:0] mag;
      m = (v < 0) ? 64'(-v) : 64'(v);
      if (m > UNIT_Q60) m = UNIT_Q60;
      m = m >> 20;
      r = (64'd32767 * m + (64'd1 << 39)) >> 40;
      mag = r[COEF_W-1:0];
      return (v < 0) ? -mag : mag;
   endfunction

   // Complex multiply of a recentred byte pair with one oscillator entry
   function automatic mixed_pair_type mix_pair(logic [SAMPLE_W-1:0] i_b,
                                               logic [SAMPLE_W-1:0] q_b, longint lut_idx);
      int             si, sq, ri, rq;
      mixed_pair_type res;
      si = int'(i_b) - 128;
      sq = int'(q_b) - 128;
      ri = si * cos_q15[lut_idx] - sq * sin_q15[lut_idx];
      rq = si * sin_q15[lut_idx] + sq * cos_q15[lut_idx];
      res.i_out = ri[RESULT_W-1:0];
      res.q_out = rq[RESULT_W-1:0];
      return res;
   endfunction

   task automatic flag_field(string what, logic signed [RESULT_W-1:0] want,
                             logic signed [RESULT_W-1:0] got);
      errs++;
      if (errs <= REPORT_LIMIT) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   // Build cosine and sine by Taylor series on the first quadrant, then fold
   initial begin : build_luts
      logic [63:0] quad, rem, x, x2, ct, st;
      longint      c, s, cq, sq;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         quad = 64'(4 * k) / LUT_DEPTH;
         rem  = 64'(4 * k) - quad * LUT_DEPTH;
         x  = (QUARTER_TURN_Q60 / LUT_DEPTH) * rem
            + ((QUARTER_TURN_Q60 % LUT_DEPTH) * rem) / LUT_DEPTH;
         x2 = q60_product(x, x);
         ct = UNIT_Q60;
         st = x;
         c  = longint'(UNIT_Q60);
         s  = longint'(x);
         for (int j = 1; j <= SERIES_TERMS; j++) begin
            ct = q60_product(ct, x2) / 64'((2 * j - 1) * (2 * j));
            st = q60_product(st, x2) / 64'((2 * j) * (2 * j + 1));
            if (j % 2 == 1) begin
               c = c - longint'(ct);
               s = s - longint'(st);
            end else begin
               c = c + longint'(ct);
               s = s + longint'(st);
            end
         end
         case (quad[1:0])
            2'd0: begin cq = c;  sq = s;  end
            2'd1: begin cq = -s; sq = c;  end
            2'd2: begin cq = -c; sq = -s; end
            default: begin cq = s; sq = -c; end
         endcase
         cos_q15[k] = q15_round(cq);
         sin_q15[k] = q15_round(sq);
      end
   end

   // Track configuration, predict on each input transfer, check each result transfer
   always @(posedge clock) begin : watch
      mixed_pair_type             due;
      longint                     lut_idx, next_phase;
      logic signed [FREQ_W-1:0]   written;
      csr_index_type              reg_idx;
      reg_idx = csr_paddr[CSR_ADDR_W-1:CSR_INDEX_LSB];
      if (reset) begin
         nco_phase   = 0;
         step_offset = 0;
         mixed_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && reg_idx == REG_FREQ_OFFSET) begin
            if (csr_pwrite) begin
               written     = csr_pwdata[FREQ_W-1:0];
               step_offset = written;
            end else if (csr_prdata[FREQ_W-1:0] !== step_offset[FREQ_W-1:0]) begin
               flag_field("frequency_offset readback", RESULT_W'(step_offset),
                          RESULT_W'(signed'(csr_prdata[FREQ_W-1:0])));
            end
         end

         // A result never leaves in the cycle its item is accepted, so pop before push
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (mixed_due.size() == 0) begin
               errs++;
               if (errs <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result i_out %0d q_out %0d", $realtime,
                           rsp_bus.i_out, rsp_bus.q_out);
               end
            end else begin
               due = mixed_due.pop_front();
               if (rsp_bus.i_out !== due.i_out) flag_field("i_out", due.i_out, rsp_bus.i_out);
               if (rsp_bus.q_out !== due.q_out) flag_field("q_out", due.q_out, rsp_bus.q_out);
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            lut_idx = (nco_phase * LUT_DEPTH) / NCO_MODULUS;
            if (lut_idx >= LUT_DEPTH) lut_idx = LUT_DEPTH - 1;
            mixed_due.push_back(mix_pair(req_bus.i_sample, req_bus.q_sample, lut_idx));
            next_phase = (nco_phase - step_offset) % NCO_MODULUS;
            if (next_phase < 0) next_phase = next_phase + NCO_MODULUS;
            nco_phase = next_phase;
         end
      end
      pending    <= mixed_due.size();
      mismatches <= errs;
   end

endmodule

// ----- tb/tb.sv -----
// Top of the IQ byte NCO mixer testbench: clock, reset, stimulus on the input
// channel and csr_ port, result-side backpressure and the verdict.
// Depends on iqnco_pkg, both channel interfaces, iq_byte_nco_mixer and iqnco_checker.
`timescale 1ns / 100ps

module tb;
   import iqnco_pkg::*;

   localparam int            CLOCK_HALF    = 6;
   localparam int            RESET_CYCLES  = 10;
   localparam int            IDLE_PERCENT  = 7;
   localparam int            RANDOM_PHASES = 9;
   localparam int            PHASE_ITEMS   = 100;
   localparam int            HOLD_CYCLES   = 80;
   localparam int            OFFSET_LIMIT  = 1023999;
   localparam int            RUN_LIMIT_NS  = 2_400_000;
   localparam csr_index_type REG_SPARE     = csr_index_type'(1);

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  steady;
   logic                  hold_request;
   logic                  hold_taken;
   int                    hold_left;
   int                    fail_total;
   int                    pending;

   iqnco_req_if req_bus ();
   iqnco_rsp_if rsp_bus ();

   iq_byte_nco_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   iqnco_checker mixer_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mismatches  (fail_total),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, none while steady
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_taken    <= 1'b0;
         hold_left     <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         hold_taken    <= 1'b1;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Offer one byte pair, with random gaps unless steady, and wait for its transfer
   task automatic offer_pair(logic [SAMPLE_W-1:0] i_b, logic [SAMPLE_W-1:0] q_b);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid    <= 1'b0;
         req_bus.i_sample <= SAMPLE_W'($urandom);
         req_bus.q_sample <= SAMPLE_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.i_sample <= i_b;
      req_bus.q_sample <= q_b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stop offering and hold until every predicted result has arrived
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // One APB setup and access; psel stays high so transfers can chain
   task automatic apb_cycle(logic is_write, csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, {CSR_INDEX_LSB{1'b0}}};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Write a register once the block is idle, then read it back
   task automatic set_offset(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      drain_results();
      apb_cycle(1'b1, idx, data);
      apb_cycle(1'b0, idx, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] word;
      int                    step;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.i_sample = '0;
      req_bus.q_sample = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      steady           = 1'b0;
      hold_request     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Zero offset: phase stays at zero, cosine full scale, sine zero
      set_offset(REG_FREQ_OFFSET, 0);
      offer_pair(8'd0, 8'd0);
      offer_pair(8'd255, 8'd255);
      offer_pair(8'd128, 8'd128);
      offer_pair(8'd0, 8'd255);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd127, 8'd129);
      offer_pair(8'h55, 8'hAA);
      offer_pair(8'hAA, 8'h55);

      // One table step per item, wrapping below zero on the first step
      set_offset(REG_FREQ_OFFSET, 2000);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd0, 8'd255);
      offer_pair(8'd0, 8'd0);
      offer_pair(8'd255, 8'd255);

      // Range extremes, then offsets beyond the stated range
      set_offset(REG_FREQ_OFFSET, -OFFSET_LIMIT);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd0, 8'd255);
      offer_pair(8'd1, 8'd254);
      set_offset(REG_FREQ_OFFSET, OFFSET_LIMIT);
      offer_pair(8'd255, 8'd255);
      offer_pair(8'd0, 8'd0);
      offer_pair(8'd200, 8'd50);
      set_offset(REG_FREQ_OFFSET, 32'hFFF0_0000);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd0, 8'd255);
      set_offset(REG_FREQ_OFFSET, 32'h000F_FFFF);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd0, 8'd255);

      // A write to an unmapped index must leave the offset alone
      set_offset(REG_SPARE, 32'hFFFF_FFFF);
      offer_pair(8'd255, 8'd0);
      offer_pair(8'd0, 8'd255);

      // Random phases, each with its own offset and random upper data bits
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0:       step = int'($urandom_range(0, 32'h1F_FFFF));
            1:       step = int'($urandom_range(0, 8000)) - 4000;
            2:       step = int'($urandom_range(0, 2 * OFFSET_LIMIT)) - OFFSET_LIMIT;
            default: step = (ph == 3) ? -OFFSET_LIMIT : OFFSET_LIMIT;
         endcase
         word             = $urandom;
         word[FREQ_W-1:0] = step[FREQ_W-1:0];
         set_offset(REG_FREQ_OFFSET, word);
         steady <= (ph == 3);
         if (ph == 5) hold_request <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 6 && n == PHASE_ITEMS / 2) drain_results();
            offer_pair(SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom_range(0, 255)));
         end
      end

      // Let the pipeline empty and watch for stray results
      drain_results();
      repeat (PIPE_STAGES + 8) @(posedge clock);
      if (fail_total == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
